/* rtl/dwpi_pkg.sv */
// package for the dual wheel pi speed regulator
// holds field widths, register codes, reset values, control types
// no dependencies
package dwpi_pkg;

   localparam int SPEED_W   = 16;
   localparam int TIME_W    = 32;
   localparam int ERR_W     = SPEED_W + 1;
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 23;
   localparam int INTEG_W   = 24;
   localparam int CMD_W     = 24;
   localparam int P_W       = GAIN_W + 1 + ERR_W;
   localparam int I_W       = GAIN_W + 1 + INTEG_W;
   localparam int INC_W     = ERR_W + TIME_W + 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_W     = LIMIT_W;

   localparam int CMD_MAX_VAL = 8388607;
   localparam int CMD_MIN_VAL = -8388608;

   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I         = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_LIMIT = 2'd2;

   localparam logic [GAIN_W-1:0]  GAIN_P_RESET         = 16'd12800;
   localparam logic [GAIN_W-1:0]  GAIN_I_RESET         = 16'd64000;
   localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RESET = 23'd3276800;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_INTEG,
      ST_IMUL,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic capture;
      logic mul;
      logic integ;
      logic imul;
   } lane_ctrl_type;

endpackage

/* rtl/dwpi_req_if.sv */
// request channel: valid, ready and one input beat
// depends on dwpi_pkg
interface dwpi_req_if import dwpi_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] right_reference;
   logic signed [SPEED_W-1:0] left_reference;
   logic signed [SPEED_W-1:0] right_measured;
   logic signed [SPEED_W-1:0] left_measured;
   logic        [TIME_W-1:0]  time_stamp;
   logic                      switch_a;
   logic                      switch_b;

   modport source (
      output valid, right_reference, left_reference, right_measured, left_measured,
             time_stamp, switch_a, switch_b,
      input  ready
   );
   modport sink (
      input  valid, right_reference, left_reference, right_measured, left_measured,
             time_stamp, switch_a, switch_b,
      output ready
   );
endinterface

/* rtl/dwpi_rsp_if.sv */
// response channel: valid, ready and one result beat
// depends on dwpi_pkg
interface dwpi_rsp_if import dwpi_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [CMD_W-1:0] right_command;
   logic signed [CMD_W-1:0] left_command;

   modport source (output valid, right_command, left_command, input ready);
   modport sink (input valid, right_command, left_command, output ready);
endinterface

/* rtl/dwpi_lane.sv */
// one wheel lane: error, integrator update with clamp, gain products
// depends on dwpi_pkg
module dwpi_lane import dwpi_pkg::*; #(
   parameter int SPEED_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lane_ctrl_type             ctrl,
   input  logic signed [SPEED_W-1:0] reference,
   input  logic signed [SPEED_W-1:0] measured,
   input  logic        [TIME_W-1:0]  dt,
   input  logic                      frozen,
   input  logic        [GAIN_W-1:0]  gain_p,
   input  logic        [GAIN_W-1:0]  gain_i,
   input  logic        [LIMIT_W-1:0] integral_limit,
   output logic signed [P_W-1:0]     p_prod,
   output logic signed [I_W-1:0]     i_prod
);

   logic signed [ERR_W-1:0]   err_ff;
   logic signed [INC_W-1:0]   inc_prod_ff;
   logic signed [P_W-1:0]     p_prod_ff;
   logic signed [I_W-1:0]     i_prod_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;

   logic signed [INC_W-1:0] inc;
   logic signed [INC_W-1:0] sum;
   logic signed [INC_W-1:0] lim_hi;
   logic signed [INC_W-1:0] lim_lo;

   always_comb begin
      inc    = inc_prod_ff >>> SPEED_FRAC_BITS;
      sum    = {{(INC_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff} + inc;
      lim_hi = {{(INC_W-LIMIT_W){1'b0}}, integral_limit};
      lim_lo = -lim_hi;
      if (sum > lim_hi) begin
         integ_in = lim_hi[INTEG_W-1:0];
      end else if (sum < lim_lo) begin
         integ_in = lim_lo[INTEG_W-1:0];
      end else begin
         integ_in = sum[INTEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         err_ff <= {reference[SPEED_W-1], reference} - {measured[SPEED_W-1], measured};
      end
      if (ctrl.mul) begin
         inc_prod_ff <= err_ff * $signed({1'b0, dt});
         p_prod_ff   <= $signed({1'b0, gain_p}) * err_ff;
      end
      if (ctrl.imul) begin
         i_prod_ff <= $signed({1'b0, gain_i}) * integ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff <= '0;
      end else if (ctrl.integ && !frozen) begin
         integ_ff <= integ_in;
      end
   end

   assign p_prod = p_prod_ff;
   assign i_prod = i_prod_ff;

endmodule

/* rtl/dwpi_merge.sv */
// merge stage: aligns and sums each lane's gain products, saturates,
// holds the result beat in an output register; depends on dwpi_pkg
module dwpi_merge import dwpi_pkg::*; #(
   parameter int SPEED_FRAC_BITS = 8,
   parameter int TIME_FRAC_BITS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   output logic                  load_ready,
   input  logic signed [P_W-1:0] right_p,
   input  logic signed [I_W-1:0] right_i,
   input  logic signed [P_W-1:0] left_p,
   input  logic signed [I_W-1:0] left_i,
   dwpi_rsp_if.source            rsp_ch
);

   localparam int PA_W  = P_W + TIME_FRAC_BITS;
   localparam int IA_W  = I_W + SPEED_FRAC_BITS;
   localparam int SUM_W = ((PA_W > IA_W) ? PA_W : IA_W) + 1;
   localparam logic signed [SUM_W-1:0] CMD_HI = SUM_W'(CMD_MAX_VAL);
   localparam logic signed [SUM_W-1:0] CMD_LO = SUM_W'(CMD_MIN_VAL);

   function automatic logic signed [CMD_W-1:0] form_command(
      input logic signed [P_W-1:0] p,
      input logic signed [I_W-1:0] i
   );
      logic signed [SUM_W-1:0] pa;
      logic signed [SUM_W-1:0] ia;
      logic signed [SUM_W-1:0] c;
      pa = {{(SUM_W-P_W){p[P_W-1]}}, p} <<< TIME_FRAC_BITS;
      ia = {{(SUM_W-I_W){i[I_W-1]}}, i} <<< SPEED_FRAC_BITS;
      c  = (pa + ia) >>> (SPEED_FRAC_BITS + TIME_FRAC_BITS);
      if (c > CMD_HI) begin
         c = CMD_HI;
      end else if (c < CMD_LO) begin
         c = CMD_LO;
      end
      return c[CMD_W-1:0];
   endfunction

   logic                    out_valid_ff;
   logic signed [CMD_W-1:0] right_cmd_ff;
   logic signed [CMD_W-1:0] left_cmd_ff;

   assign load_ready = !out_valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         right_cmd_ff <= form_command(right_p, right_i);
         left_cmd_ff  <= form_command(left_p, left_i);
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.right_command = right_cmd_ff;
   assign rsp_ch.left_command  = left_cmd_ff;

endmodule

/* rtl/dual_wheel_pi_speed_regulator_unit.sv */
// dual wheel pi speed regulator, top level
// the request beat is taken in idle, then the sequencer steps through
// error/dt multiply, integrator clamp, integral multiply and merge, which
// waits for room in the output register; no new beat is taken until then
// reset: synchronous, restores gains and limit, zeroes integrators and previous time
// depends on dwpi_pkg, dwpi_req_if, dwpi_rsp_if, dwpi_lane, dwpi_merge
module dual_wheel_pi_speed_regulator_unit import dwpi_pkg::*; #(
   parameter int SPEED_FRAC_BITS = 8,
   parameter int TIME_FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   dwpi_req_if.sink             req_ch,
   dwpi_rsp_if.source           rsp_ch,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   state_type state_ff;
   state_type state_in;

   logic [GAIN_W-1:0]  gain_p_ff;
   logic [GAIN_W-1:0]  gain_i_ff;
   logic [LIMIT_W-1:0] integral_limit_ff;
   logic [TIME_W-1:0]  prev_time_ff;
   logic [TIME_W-1:0]  dt_ff;
   logic               frozen_ff;

   lane_ctrl_type ctrl;
   logic          accept;
   logic          load;
   logic          load_ready;

   logic signed [P_W-1:0] right_p;
   logic signed [I_W-1:0] right_i;
   logic signed [P_W-1:0] left_p;
   logic signed [I_W-1:0] left_i;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= GAIN_P_RESET;
         gain_i_ff         <= GAIN_I_RESET;
         integral_limit_ff <= INTEGRAL_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_GAIN_P:         gain_p_ff         <= csr_write_data[GAIN_W-1:0];
            REG_GAIN_I:         gain_i_ff         <= csr_write_data[GAIN_W-1:0];
            REG_INTEGRAL_LIMIT: integral_limit_ff <= csr_write_data[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_time_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            prev_time_ff <= req_ch.time_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dt_ff     <= req_ch.time_stamp - prev_time_ff;
         frozen_ff <= req_ch.switch_a || req_ch.switch_b;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      load         = 1'b0;
      req_ch.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            ctrl.capture = req_ch.valid;
            if (req_ch.valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            ctrl.mul = 1'b1;
            state_in = ST_INTEG;
         end
         ST_INTEG: begin
            ctrl.integ = 1'b1;
            state_in   = ST_IMUL;
         end
         ST_IMUL: begin
            ctrl.imul = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            load = load_ready;
            if (load_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign accept = req_ch.valid && req_ch.ready;

   dwpi_lane #(.SPEED_FRAC_BITS(SPEED_FRAC_BITS)) u_right_lane (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .reference      (req_ch.right_reference),
      .measured       (req_ch.right_measured),
      .dt             (dt_ff),
      .frozen         (frozen_ff),
      .gain_p         (gain_p_ff),
      .gain_i         (gain_i_ff),
      .integral_limit (integral_limit_ff),
      .p_prod         (right_p),
      .i_prod         (right_i)
   );

   dwpi_lane #(.SPEED_FRAC_BITS(SPEED_FRAC_BITS)) u_left_lane (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .reference      (req_ch.left_reference),
      .measured       (req_ch.left_measured),
      .dt             (dt_ff),
      .frozen         (frozen_ff),
      .gain_p         (gain_p_ff),
      .gain_i         (gain_i_ff),
      .integral_limit (integral_limit_ff),
      .p_prod         (left_p),
      .i_prod         (left_i)
   );

   dwpi_merge #(
      .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
      .TIME_FRAC_BITS  (TIME_FRAC_BITS)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_ready (load_ready),
      .right_p    (right_p),
      .right_i    (right_i),
      .left_p     (left_p),
      .left_i     (left_i),
      .rsp_ch     (rsp_ch)
   );

endmodule
